@@ rtl/prpi_pkg.sv @@
package prpi_pkg;

  localparam int unsigned MaxNodes  = 1024;
  localparam int unsigned MaxEdges  = 8192;
  localparam int unsigned NodeAw    = $clog2(MaxNodes);
  localparam int unsigned EdgeAw    = $clog2(MaxEdges);

  localparam int unsigned TypeW     = 2;
  localparam int unsigned IndexW    = 13;
  localparam int unsigned StartW    = 14;
  localparam int unsigned DegW      = 14;
  localparam int unsigned SrcW      = 10;
  localparam int unsigned ScoreW    = 32;
  localparam int unsigned IterW     = 16;
  localparam int unsigned NodeCntW  = 11;
  localparam int unsigned EdgeCntW  = 14;
  localparam int unsigned DampW     = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [TypeW-1:0] {
    ReqLoadNode = 2'd0,
    ReqLoadEdge = 2'd1,
    ReqRun      = 2'd2,
    ReqRead     = 2'd3
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNodeCount   = 3'd0,
    CfgEdgeCount   = 3'd1,
    CfgDamping     = 3'd2,
    CfgConvLimit   = 3'd3,
    CfgMaxIter     = 3'd4
  } cfg_idx_e;

  function automatic logic [ScoreW-1:0] sat_add(input logic [ScoreW-1:0] a,
                                                 input logic [ScoreW-1:0] b);
    logic [ScoreW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ScoreW] ? {ScoreW{1'b1}} : s[ScoreW-1:0];
  endfunction

endpackage

@@ rtl/prpi_intf.sv @@
interface prpi_req_if import prpi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TypeW-1:0]   req_type;
  logic [IndexW-1:0]  index;
  logic [StartW-1:0]  node_in_start;
  logic [DegW-1:0]    node_out_degree;
  logic [SrcW-1:0]    edge_source;
  modport source (output valid, req_type, index, node_in_start, node_out_degree,
                  edge_source, input ready);
  modport sink (input valid, req_type, index, node_in_start, node_out_degree,
                edge_source, output ready);
endinterface

interface prpi_rsp_if import prpi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ScoreW-1:0] score;
  logic [IterW-1:0]  iterations;
  logic              converged;
  modport source (output valid, score, iterations, converged, input ready);
  modport sink (input valid, score, iterations, converged, output ready);
endinterface

interface prpi_cfg_if import prpi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/prpi_ram.sv @@
module prpi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/prpi_div.sv @@
module prpi_div import prpi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ScoreW-1:0] dividend_i,
  input  logic [DegW-1:0]   divisor_i,
  output logic              done_o,
  output logic [ScoreW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(ScoreW + 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [ScoreW-1:0] quo_q, quo_d;
  logic [DegW-1:0]   rem_q, rem_d;
  logic [DegW-1:0]   dvs_q, dvs_d;
  logic [DegW:0]     trial;
  logic              ge;

  always_comb begin
    trial  = {rem_q, quo_q[ScoreW-1]};
    ge     = trial >= {1'b0, dvs_q};
    cnt_d  = cnt_q;
    done_d = done_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d  = CntW'(ScoreW);
      done_d = 1'b0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (cnt_q != '0) begin
      rem_d = ge ? DegW'(trial - {1'b0, dvs_q}) : trial[DegW-1:0];
      quo_d = {quo_q[ScoreW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/pagerank_power_iteration.sv @@
// PageRank power-iteration engine.
// req_i carries one item per beat: load node, load edge, run, or read score.
// rsp_o returns one beat per read item: score (Q1.31), iterations and
// converged of the last run. cfg_i writes the five registers by index and
// is always ready; write it only while the engine is idle.
// Load items stream at one per cycle while the engine is idle.
// A read goes through one score memory read and S_RD to reach the output
// register; loads are accepted while a response waits in that register.
// A run holds req_i ready low until done. Setting the start scores and each
// iteration are paced by the single bit-serial divider, used also once per
// edge with a valid source, and by the one-read-per-cycle memory ports
// walked node by node and edge by edge.
// Reset sets config defaults and control state, not datapath registers;
// graph and score memories are undefined until loaded or a run writes them.
// When rsp_o is stalled, the response holds and a further read waits in the
// engine, blocking req_i until the output register frees up.
module pagerank_power_iteration import prpi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  prpi_req_if.sink     req_i,
  prpi_rsp_if.source   rsp_o,
  prpi_cfg_if.sink     cfg_i
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_RD       = 5'd1;
  localparam logic [4:0] S_INIT_S   = 5'd2;
  localparam logic [4:0] S_INIT_W   = 5'd3;
  localparam logic [4:0] S_INIT_WR  = 5'd4;
  localparam logic [4:0] S_BASE_S   = 5'd5;
  localparam logic [4:0] S_BASE_W   = 5'd6;
  localparam logic [4:0] S_DS_RD    = 5'd7;
  localparam logic [4:0] S_DS_ACC   = 5'd8;
  localparam logic [4:0] S_DS_MUL   = 5'd9;
  localparam logic [4:0] S_DANG_S   = 5'd10;
  localparam logic [4:0] S_DANG_W   = 5'd11;
  localparam logic [4:0] S_ND_LO    = 5'd12;
  localparam logic [4:0] S_ND_HI    = 5'd13;
  localparam logic [4:0] S_ND_HIW   = 5'd14;
  localparam logic [4:0] S_EDGE_CHK = 5'd15;
  localparam logic [4:0] S_EDGE_SRC = 5'd16;
  localparam logic [4:0] S_EDGE_DAT = 5'd17;
  localparam logic [4:0] S_EDGE_DIV = 5'd18;
  localparam logic [4:0] S_NV_MUL   = 5'd19;
  localparam logic [4:0] S_NV_SUM   = 5'd20;
  localparam logic [4:0] S_NV_WR    = 5'd21;
  localparam logic [4:0] S_CP_RD    = 5'd22;
  localparam logic [4:0] S_CP_WR    = 5'd23;
  localparam logic [4:0] S_CHK      = 5'd24;

  localparam int unsigned MulW = ScoreW + DampW;

  // configuration
  logic [NodeCntW-1:0] node_count_q;
  logic [EdgeCntW-1:0] edge_count_q;
  logic [DampW-1:0]    damping_q;
  logic [ScoreW-1:0]   conv_limit_q;
  logic [IterW-1:0]    max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCntW'(1);
      edge_count_q <= '0;
      damping_q    <= DampW'(55705);
      conv_limit_q <= ScoreW'(21475);
      max_iter_q   <= IterW'(1000);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgNodeCount: node_count_q <= cfg_i.data[NodeCntW-1:0];
        CfgEdgeCount: edge_count_q <= cfg_i.data[EdgeCntW-1:0];
        CfgDamping:   damping_q    <= cfg_i.data[DampW-1:0];
        CfgConvLimit: conv_limit_q <= cfg_i.data[ScoreW-1:0];
        CfgMaxIter:   max_iter_q   <= cfg_i.data[IterW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  logic [NodeCntW-1:0] n_eff, n_last;
  logic [EdgeCntW-1:0] e_eff;
  logic [IterW-1:0]    cap;

  always_comb begin
    if (node_count_q == '0) begin
      n_eff = NodeCntW'(1);
    end else if (node_count_q > NodeCntW'(MaxNodes)) begin
      n_eff = NodeCntW'(MaxNodes);
    end else begin
      n_eff = node_count_q;
    end
    n_last = n_eff - 1'b1;
    e_eff  = (edge_count_q > EdgeCntW'(MaxEdges)) ? EdgeCntW'(MaxEdges) : edge_count_q;
    cap    = (max_iter_q == '0) ? IterW'(1) : max_iter_q;
  end

  // control state
  logic [4:0]          state_q, state_d;
  logic [NodeCntW-1:0] v_q, v_d;
  logic [EdgeCntW-1:0] k_q, k_d;
  logic [EdgeCntW-1:0] hi_q, hi_d;
  logic [IterW-1:0]    cnt_q, cnt_d;
  logic [IterW-1:0]    iter_q, iter_d;
  logic                conv_q, conv_d;
  logic                out_valid_q, out_valid_d;
  logic                rd_oor_q, rd_oor_d;

  // datapath
  logic [ScoreW-1:0]   init_q, init_d;
  logic [ScoreW-1:0]   base_q, base_d;
  logic [ScoreW-1:0]   dang_q, dang_d;
  logic [ScoreW-1:0]   acc_q, acc_d;
  logic [ScoreW-1:0]   sub_q, sub_d;
  logic [ScoreW-1:0]   diff_q, diff_d;
  logic [ScoreW-1:0]   nv_q, nv_d;
  logic [ScoreW-1:0]   old_q, old_d;
  logic [MulW-1:0]     mul_q, mul_d;
  logic [SrcW-1:0]     src_q, src_d;
  logic [ScoreW-1:0]   out_score_q, out_score_d;
  logic [IterW-1:0]    out_iter_q, out_iter_d;
  logic                out_conv_q, out_conv_d;

  // memory ports
  logic              is_we, is_re;
  logic [NodeAw-1:0] is_raddr;
  logic [StartW-1:0] is_rdata;
  logic              od_we, od_re;
  logic [NodeAw-1:0] od_raddr;
  logic [DegW-1:0]   od_rdata;
  logic              es_we, es_re;
  logic [SrcW-1:0]   es_rdata;
  logic              sc_we, sc_re;
  logic [NodeAw-1:0] sc_waddr, sc_raddr;
  logic [ScoreW-1:0] sc_wdata, sc_rdata;
  logic              nx_we, nx_re;
  logic [ScoreW-1:0] nx_rdata;

  // divider
  logic              div_start, div_done;
  logic [ScoreW-1:0] div_a, div_q;
  logic [DegW-1:0]   div_b;

  logic              req_fire, out_free;
  logic [NodeAw-1:0] v_addr, v_next_addr;
  logic [ScoreW+1:0] nv_sum;
  logic [ScoreW-1:0] abs_diff;
  logic [DampW:0]    base_num;

  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign v_addr      = v_q[NodeAw-1:0];
  assign v_next_addr = NodeAw'(v_q + 1'b1);
  assign base_num    = (DampW+1)'(1 << DampW) - {1'b0, damping_q};
  assign nv_sum      = {2'b00, mul_q[MulW-1:DampW]} + {2'b00, base_q} + {2'b00, dang_q};
  assign abs_diff    = (nv_q >= old_q) ? nv_q - old_q : old_q - nv_q;

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    k_d         = k_q;
    hi_d        = hi_q;
    cnt_d       = cnt_q;
    iter_d      = iter_q;
    conv_d      = conv_q;
    out_valid_d = out_valid_q;
    rd_oor_d    = rd_oor_q;
    init_d      = init_q;
    base_d      = base_q;
    dang_d      = dang_q;
    acc_d       = acc_q;
    sub_d       = sub_q;
    diff_d      = diff_q;
    nv_d        = nv_q;
    old_d       = old_q;
    mul_d       = mul_q;
    src_d       = src_q;
    out_score_d = out_score_q;
    out_iter_d  = out_iter_q;
    out_conv_d  = out_conv_q;

    is_we    = 1'b0;
    is_re    = 1'b0;
    is_raddr = v_addr;
    od_we    = 1'b0;
    od_re    = 1'b0;
    od_raddr = v_addr;
    es_we    = 1'b0;
    es_re    = 1'b0;
    sc_we    = 1'b0;
    sc_re    = 1'b0;
    sc_waddr = v_addr;
    sc_wdata = init_q;
    sc_raddr = v_addr;
    nx_we    = 1'b0;
    nx_re    = 1'b0;

    div_start = 1'b0;
    div_a     = sc_rdata;
    div_b     = od_rdata;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          case (req_i.req_type)
            ReqLoadNode: begin
              if (req_i.index < IndexW'(MaxNodes)) begin
                is_we = 1'b1;
                od_we = 1'b1;
              end
            end
            ReqLoadEdge: begin
              // every 13-bit index lies below MaxEdges
              es_we = 1'b1;
            end
            ReqRun: begin
              state_d = S_INIT_S;
            end
            default: begin
              sc_re    = 1'b1;
              sc_raddr = req_i.index[NodeAw-1:0];
              rd_oor_d = req_i.index >= IndexW'(MaxNodes);
              state_d  = S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_score_d = rd_oor_q ? '0 : sc_rdata;
          out_iter_d  = iter_q;
          out_conv_d  = conv_q;
          state_d     = S_IDLE;
        end
      end
      S_INIT_S: begin
        div_start = 1'b1;
        div_a     = ScoreW'(1) << (ScoreW - 1);
        div_b     = DegW'(n_eff);
        state_d   = S_INIT_W;
      end
      S_INIT_W: begin
        if (div_done) begin
          init_d  = div_q;
          v_d     = '0;
          state_d = S_INIT_WR;
        end
      end
      S_INIT_WR: begin
        sc_we = 1'b1;
        if (v_q == n_last) begin
          cnt_d   = '0;
          state_d = S_BASE_S;
        end else begin
          v_d = v_q + 1'b1;
        end
      end
      S_BASE_S: begin
        div_start = 1'b1;
        div_a     = {base_num, (ScoreW-DampW-1)'(0)};
        div_b     = DegW'(n_eff);
        state_d   = S_BASE_W;
      end
      S_BASE_W: begin
        if (div_done) begin
          base_d  = div_q;
          v_d     = '0;
          acc_d   = '0;
          state_d = S_DS_RD;
        end
      end
      S_DS_RD: begin
        od_re   = 1'b1;
        sc_re   = 1'b1;
        state_d = S_DS_ACC;
      end
      S_DS_ACC: begin
        if (od_rdata == '0) begin
          acc_d = sat_add(acc_q, sc_rdata);
        end
        if (v_q == n_last) begin
          state_d = S_DS_MUL;
        end else begin
          v_d     = v_q + 1'b1;
          state_d = S_DS_RD;
        end
      end
      S_DS_MUL: begin
        mul_d   = acc_q * damping_q;
        state_d = S_DANG_S;
      end
      S_DANG_S: begin
        div_start = 1'b1;
        div_a     = mul_q[MulW-1:DampW];
        div_b     = DegW'(n_eff);
        state_d   = S_DANG_W;
      end
      S_DANG_W: begin
        if (div_done) begin
          dang_d  = div_q;
          v_d     = '0;
          diff_d  = '0;
          state_d = S_ND_LO;
        end
      end
      S_ND_LO: begin
        is_re   = 1'b1;
        state_d = S_ND_HI;
      end
      S_ND_HI: begin
        k_d      = (is_rdata > e_eff) ? e_eff : is_rdata;
        is_re    = 1'b1;
        is_raddr = v_next_addr;
        state_d  = S_ND_HIW;
      end
      S_ND_HIW: begin
        if (v_q == n_last) begin
          hi_d = e_eff;
        end else begin
          hi_d = (is_rdata > e_eff) ? e_eff : is_rdata;
        end
        sub_d   = '0;
        state_d = S_EDGE_CHK;
      end
      S_EDGE_CHK: begin
        if (k_q >= hi_q) begin
          state_d = S_NV_MUL;
        end else begin
          es_re   = 1'b1;
          state_d = S_EDGE_SRC;
        end
      end
      S_EDGE_SRC: begin
        src_d    = es_rdata;
        od_re    = 1'b1;
        od_raddr = es_rdata;
        sc_re    = 1'b1;
        sc_raddr = es_rdata;
        state_d  = S_EDGE_DAT;
      end
      S_EDGE_DAT: begin
        if ({1'b0, src_q} < n_eff && od_rdata != '0) begin
          div_start = 1'b1;
          state_d   = S_EDGE_DIV;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_EDGE_CHK;
        end
      end
      S_EDGE_DIV: begin
        if (div_done) begin
          sub_d   = sat_add(sub_q, div_q);
          k_d     = k_q + 1'b1;
          state_d = S_EDGE_CHK;
        end
      end
      S_NV_MUL: begin
        mul_d   = sub_q * damping_q;
        sc_re   = 1'b1;
        state_d = S_NV_SUM;
      end
      S_NV_SUM: begin
        nv_d    = (nv_sum[ScoreW+1:ScoreW] != 2'b00) ? {ScoreW{1'b1}} : nv_sum[ScoreW-1:0];
        old_d   = sc_rdata;
        state_d = S_NV_WR;
      end
      S_NV_WR: begin
        nx_we  = 1'b1;
        diff_d = sat_add(diff_q, abs_diff);
        if (v_q == n_last) begin
          v_d     = '0;
          state_d = S_CP_RD;
        end else begin
          v_d     = v_q + 1'b1;
          state_d = S_ND_LO;
        end
      end
      S_CP_RD: begin
        nx_re   = 1'b1;
        state_d = S_CP_WR;
      end
      S_CP_WR: begin
        sc_we    = 1'b1;
        sc_wdata = nx_rdata;
        if (v_q == n_last) begin
          state_d = S_CHK;
        end else begin
          v_d     = v_q + 1'b1;
          state_d = S_CP_RD;
        end
      end
      S_CHK: begin
        cnt_d = cnt_q + 1'b1;
        if (diff_q >= conv_limit_q && (cnt_q + 1'b1) < cap) begin
          state_d = S_BASE_S;
        end else begin
          iter_d  = cnt_q + 1'b1;
          conv_d  = diff_q < conv_limit_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      v_q         <= '0;
      k_q         <= '0;
      hi_q        <= '0;
      cnt_q       <= '0;
      iter_q      <= '0;
      conv_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rd_oor_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      v_q         <= v_d;
      k_q         <= k_d;
      hi_q        <= hi_d;
      cnt_q       <= cnt_d;
      iter_q      <= iter_d;
      conv_q      <= conv_d;
      out_valid_q <= out_valid_d;
      rd_oor_q    <= rd_oor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    init_q      <= init_d;
    base_q      <= base_d;
    dang_q      <= dang_d;
    acc_q       <= acc_d;
    sub_q       <= sub_d;
    diff_q      <= diff_d;
    nv_q        <= nv_d;
    old_q       <= old_d;
    mul_q       <= mul_d;
    src_q       <= src_d;
    out_score_q <= out_score_d;
    out_iter_q  <= out_iter_d;
    out_conv_q  <= out_conv_d;
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.score      = out_score_q;
  assign rsp_o.iterations = out_iter_q;
  assign rsp_o.converged  = out_conv_q;

  prpi_ram #(.Width(StartW), .Depth(MaxNodes)) u_in_start_mem (
    .clk_i   (clk_i),
    .we_i    (is_we),
    .waddr_i (req_i.index[NodeAw-1:0]),
    .wdata_i (req_i.node_in_start),
    .re_i    (is_re),
    .raddr_i (is_raddr),
    .rdata_o (is_rdata)
  );

  prpi_ram #(.Width(DegW), .Depth(MaxNodes)) u_out_degree_mem (
    .clk_i   (clk_i),
    .we_i    (od_we),
    .waddr_i (req_i.index[NodeAw-1:0]),
    .wdata_i (req_i.node_out_degree),
    .re_i    (od_re),
    .raddr_i (od_raddr),
    .rdata_o (od_rdata)
  );

  prpi_ram #(.Width(SrcW), .Depth(MaxEdges)) u_edge_source_mem (
    .clk_i   (clk_i),
    .we_i    (es_we),
    .waddr_i (req_i.index[EdgeAw-1:0]),
    .wdata_i (req_i.edge_source),
    .re_i    (es_re),
    .raddr_i (k_q[EdgeAw-1:0]),
    .rdata_o (es_rdata)
  );

  prpi_ram #(.Width(ScoreW), .Depth(MaxNodes)) u_score_mem (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (sc_waddr),
    .wdata_i (sc_wdata),
    .re_i    (sc_re),
    .raddr_i (sc_raddr),
    .rdata_o (sc_rdata)
  );

  prpi_ram #(.Width(ScoreW), .Depth(MaxNodes)) u_next_score_mem (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (v_addr),
    .wdata_i (nv_q),
    .re_i    (nx_re),
    .raddr_i (v_addr),
    .rdata_o (nx_rdata)
  );

  prpi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

endmodule

@@ sim/tb_intf_note.sv @@
`timescale 1ns / 100ps
// Channel interfaces come from the RTL; this unit only holds shared testbench types.
package tb_pr_types;
  import prpi_pkg::*;
  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [IterW-1:0]  iterations;
    logic              converged;
  } score_rsp_t;
endpackage

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
  import prpi_pkg::*;
  import tb_pr_types::*;

  localparam int unsigned IdleLimit = 150000;

  logic clk;
  logic rst_n;

  prpi_req_if req_if ();
  prpi_rsp_if rsp_if ();
  prpi_cfg_if cfg_if ();

  pagerank_power_iteration DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of registers and stores
  logic [NodeCntW-1:0] reg_nodes;
  logic [EdgeCntW-1:0] reg_edges;
  logic [DampW-1:0]    reg_damp;
  logic [31:0]         reg_limit;
  logic [IterW-1:0]    reg_cap;
  logic [StartW-1:0]   sh_in_start [MaxNodes];
  logic [DegW-1:0]     sh_out_deg  [MaxNodes];
  logic [SrcW-1:0]     sh_src      [MaxEdges];
  logic [ScoreW-1:0]   sh_score    [MaxNodes];
  logic [ScoreW-1:0]   sh_next     [MaxNodes];
  bit                  score_set   [MaxNodes];
  logic [IterW-1:0]    sh_iters;
  logic                sh_conv;

  score_rsp_t expected_scores[$];
  int errors;
  int burst_left;
  int stall_left;
  int stall_mode;
  int idle_cycles;

  function automatic longint unsigned clip_sum(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
  endfunction

  function automatic int unsigned used_nodes();
    if (reg_nodes == 0) return 1;
    if (reg_nodes > MaxNodes) return MaxNodes;
    return reg_nodes;
  endfunction

  function automatic int unsigned used_edges();
    return (reg_edges > MaxEdges) ? MaxEdges : reg_edges;
  endfunction

  function automatic longint unsigned rank_pass(longint unsigned n, longint unsigned e);
    longint unsigned d, base, dsum, dang, diff, lo, hi, sub, nv, old, src;
    d = reg_damp;
    base = ((65536 - d) << 15) / n;
    dsum = 0;
    diff = 0;
    for (int v = 0; v < n; v++)
      if (sh_out_deg[v] == 0) dsum = clip_sum(dsum, sh_score[v]);
    dang = ((dsum * d) >> 16) / n;
    for (int v = 0; v < n; v++) begin
      lo = sh_in_start[v];
      hi = (v == n - 1) ? e : sh_in_start[v+1];
      if (lo > e) lo = e;
      if (hi > e) hi = e;
      sub = 0;
      for (longint unsigned k = lo; k < hi; k++) begin
        src = sh_src[k];
        if (src < n && sh_out_deg[src] != 0)
          sub = clip_sum(sub, sh_score[src] / sh_out_deg[src]);
      end
      nv = clip_sum(clip_sum((d * sub) >> 16, base), dang);
      sh_next[v] = nv[31:0];
      old = sh_score[v];
      diff = clip_sum(diff, (nv >= old) ? nv - old : old - nv);
    end
    for (int v = 0; v < n; v++) sh_score[v] = sh_next[v];
    return diff;
  endfunction

  function automatic void rank_run();
    longint unsigned n, e, diff;
    int unsigned cap, cnt;
    n = used_nodes();
    e = used_edges();
    cap = (reg_cap == 0) ? 1 : reg_cap;
    cnt = 0;
    for (int v = 0; v < n; v++) begin
      sh_score[v] = 32'((64'd1 << 31) / n);
      score_set[v] = 1;
    end
    do begin
      diff = rank_pass(n, e);
      cnt++;
    end while (diff >= reg_limit && cnt < cap);
    sh_iters = cnt[IterW-1:0];
    sh_conv = (diff < reg_limit);
  endfunction

  function automatic void apply_item(req_type_e t, logic [IndexW-1:0] idx,
                                     logic [StartW-1:0] st, logic [DegW-1:0] dg,
                                     logic [SrcW-1:0] sr);
    score_rsp_t r;
    case (t)
      ReqLoadNode: if (idx < MaxNodes) begin
        sh_in_start[idx] = st;
        sh_out_deg[idx] = dg;
      end
      ReqLoadEdge: if (idx < MaxEdges) sh_src[idx] = sr;
      ReqRun: rank_run();
      default: begin
        r.score = (idx < MaxNodes) ? sh_score[idx] : '0;
        r.iterations = sh_iters;
        r.converged = sh_conv;
        expected_scores.push_back(r);
      end
    endcase
  endfunction

  task automatic send_item(req_type_e t, logic [IndexW-1:0] idx, logic [StartW-1:0] st,
                           logic [DegW-1:0] dg, logic [SrcW-1:0] sr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.req_type <= t;
    req_if.index <= idx;
    req_if.node_in_start <= st;
    req_if.node_out_degree <= dg;
    req_if.edge_source <= sr;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    apply_item(t, idx, st, dg, sr);
  endtask

  task automatic send_read(logic [IndexW-1:0] idx);
    send_item(ReqRead, idx, $urandom, $urandom, $urandom);
  endtask

  task automatic send_run();
    send_item(ReqRun, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic req_quiet();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_scores.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e r, logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= r;
    cfg_if.data <= val;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    case (r)
      CfgNodeCount: reg_nodes = val[NodeCntW-1:0];
      CfgEdgeCount: reg_edges = val[EdgeCntW-1:0];
      CfgDamping:   reg_damp = val[DampW-1:0];
      CfgConvLimit: reg_limit = val;
      default:      reg_cap = val[IterW-1:0];
    endcase
  endtask

  task automatic set_regs(int unsigned n, int unsigned e, int unsigned d,
                          logic [31:0] lim, int unsigned cap);
    req_quiet();
    write_reg(CfgNodeCount, n);
    write_reg(CfgEdgeCount, e);
    write_reg(CfgDamping, d);
    write_reg(CfgConvLimit, lim);
    write_reg(CfgMaxIter, cap);
    cfg_if.valid <= 1'b0;
  endtask

  // Loads every node in use and every edge a run can reach, so a run
  // touches only written entries. Far starts leave every range empty.
  task automatic load_graph(bit tidy, bit far_starts);
    int unsigned n, e, st;
    logic [DegW-1:0] dg;
    n = used_nodes();
    e = used_edges();
    st = 0;
    for (int v = 0; v < n; v++) begin
      if (far_starts) st = $urandom_range(MaxEdges, 16383);
      else if (tidy) st = (st + $urandom_range(0, 3) > e) ? e : st + $urandom_range(0, 3);
      else st = $urandom_range(0, 16383);
      dg = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
      send_item(ReqLoadNode, v, st, dg, $urandom);
    end
    if (!far_starts)
      for (int k = 0; k < e; k++)
        send_item(ReqLoadEdge, k, $urandom, $urandom,
                  ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, n - 1));
  endtask

  function automatic logic [IndexW-1:0] pick_read();
    logic [IndexW-1:0] idx;
    idx = $urandom;
    if ($urandom_range(0, 3) != 0) idx = idx % used_nodes();
    if (idx < MaxNodes && !score_set[idx]) idx = idx % used_nodes();
    return idx;
  endfunction

  task automatic test_reset_state();
    send_read(13'd4095);
    send_read(13'd1024);
    send_run();
    send_read(13'd0);
  endtask

  task automatic test_extremes();
    set_regs(3, 4, 0, 32'hFFFF_FFFF, 0);
    load_graph(1, 0);
    send_run();
    send_read(0);
    send_read(2);
    set_regs(0, 2, 65535, 0, 5);
    load_graph(1, 0);
    send_run();
    send_read(0);
    send_read(13'h1FFF);
    set_regs(3, 16383, 30000, 0, 3);
    load_graph(0, 1);
    send_run();
    send_read(1);
    send_item(ReqLoadNode, 13'h1FFF, 14'h3FFF, 14'h3FFF, 10'h3FF);
    send_item(ReqLoadNode, 13'd1024, '0, '0, '0);
    send_read(2);
  endtask

  task automatic test_full_graph();
    set_regs(2047, 0, $urandom_range(0, 65535), 0, 2);
    load_graph(0, 0);
    send_run();
    send_read(13'd1023);
    send_read(13'd0);
    send_read(13'd512);
    send_read(13'd5000);
  endtask

  task automatic test_random_phases();
    int unsigned n, e, d, cap;
    logic [31:0] lim;
    for (int p = 0; p < 38; p++) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(1, 8);
      e = $urandom_range(0, 20);
      case ($urandom_range(0, 4))
        0: d = 0;
        1: d = 65535;
        default: d = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 5))
        0: lim = 0;
        1: lim = 32'hFFFF_FFFF;
        2: lim = 21475;
        default: lim = $urandom_range(0, 32'h00FF_FFFF);
      endcase
      cap = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
      set_regs(n, e, d, lim, cap);
      if ($urandom_range(0, 2) == 0) send_read(pick_read());
      load_graph($urandom_range(0, 4) != 0, $urandom_range(0, 9) == 0);
      repeat ($urandom_range(0, 2))
        send_item($urandom_range(0, 1) ? ReqLoadEdge : ReqLoadNode,
                  $urandom_range(MaxNodes, 8191), $urandom, $urandom, $urandom);
      send_run();
      repeat ($urandom_range(2, 6)) send_read(pick_read());
    end
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= $urandom_range(0, 1);
      default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    score_rsp_t w;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_scores.size() == 0) begin
        report("unexpected beat", rsp_if.score, 0);
      end else begin
        w = expected_scores.pop_front();
        if (rsp_if.score !== w.score) report("score", rsp_if.score, w.score);
        if (rsp_if.iterations !== w.iterations)
          report("iterations", rsp_if.iterations, w.iterations);
        if (rsp_if.converged !== w.converged)
          report("converged", rsp_if.converged, w.converged);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    errors = 0;
    burst_left = 0;
    stall_left = 0;
    stall_mode = 0;
    idle_cycles = 0;
    req_if.valid = 1'b0;
    req_if.req_type = ReqRead;
    req_if.index = '0;
    req_if.node_in_start = '0;
    req_if.node_out_degree = '0;
    req_if.edge_source = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CfgNodeCount;
    cfg_if.data = '0;
    reg_nodes = 1;
    reg_edges = 0;
    reg_damp = 55705;
    reg_limit = 21475;
    reg_cap = 1000;
    sh_iters = 0;
    sh_conv = 1'b0;
    for (int i = 0; i < MaxNodes; i++) begin
      sh_in_start[i] = '0;
      sh_out_deg[i] = '0;
      sh_score[i] = '0;
      score_set[i] = 0;
    end
    for (int i = 0; i < MaxEdges; i++) sh_src[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_item(ReqLoadNode, 0, 0, 0, 0);
    test_reset_state();
    test_extremes();
    test_full_graph();
    test_random_phases();
    req_quiet();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/prpi_pkg.sv
rtl/prpi_intf.sv
rtl/prpi_ram.sv
rtl/prpi_div.sv
rtl/pagerank_power_iteration.sv
sim/tb_intf_note.sv
sim/tb_top.sv
